[design/sgd_pkg.sv]
// ----------------------------------------------------------------------------
// sgd_pkg: shared types and constants for the sustained growth detector
// Widths, register indexes, reset values, suspect codes and the sequencer
// step encoding used by the control and datapath files.
// ----------------------------------------------------------------------------
package sgd_pkg;

  localparam int BYTE_WIDTH = 48;            // width of every byte count
  localparam int RUN_WIDTH  = 16;            // growth run counter width
  localparam int THR_W      = 12;
  localparam int SUS_W      = 16;
  localparam int CFG_W      = 16;            // widest register
  localparam int CFG_IDX_W  = 1;
  localparam int RUN_OUT_W  = 16;
  localparam int RATIO_W    = 32;
  localparam int CNT32_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int SUSP_W     = 2;
  localparam int PROD_W     = BYTE_WIDTH + THR_W;
  localparam int ALU_W      = PROD_W;        // covers products and the remainder
  localparam int REM_W      = BYTE_WIDTH + 1;
  localparam int DIV_STEPS  = RATIO_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [THR_W-1:0] GROWTH_SCALE = THR_W'(1000);
  localparam logic [THR_W-1:0] THR_RESET    = THR_W'(1050);
  localparam logic [SUS_W-1:0] SUS_RESET    = SUS_W'(10);
  localparam logic [RUN_WIDTH-1:0] RUN_MAX  = {RUN_WIDTH{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN   = 1'b1;

  localparam logic [SUSP_W-1:0] SUSP_NONE  = 2'd0;
  localparam logic [SUSP_W-1:0] SUSP_FRAME = 2'd1;
  localparam logic [SUSP_W-1:0] SUSP_GPU   = 2'd2;
  localparam logic [SUSP_W-1:0] SUSP_HEAP  = 2'd3;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_GROW,
    S_DF,
    S_DG,
    S_DH,
    S_C1,
    S_C2,
    S_C3,
    S_SAT,
    S_DIV,
    S_FIN,
    S_OUT
  } sgd_step_e;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic action;
    logic have_prev;
    logic grow;
    logic sat;
  } sgd_sts_t;

  // control from the sequencer to the datapath
  typedef struct packed {
    sgd_step_e step;
    logic      accept;
    logic      in_stall;
    logic      out_valid;
  } sgd_ctl_t;

endpackage

[design/sgd_alu.sv]
// ----------------------------------------------------------------------------
// sgd_alu: shared subtract and compare unit
// Forms a - b and flags a >= b, unsigned; the growth, overflow and suspect
// compares, pool deltas and division steps all go through this one unit.
// ----------------------------------------------------------------------------
module sgd_alu
  import sgd_pkg::*;
(
  input  logic [ALU_W-1:0] a_i,
  input  logic [ALU_W-1:0] b_i,
  output logic [ALU_W-1:0] diff_o,
  output logic             ge_o
);

  logic [ALU_W:0] wide;

  assign wide   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = wide[ALU_W-1:0];
  assign ge_o   = ~wide[ALU_W];

endmodule

[design/sgd_ctrl.sv]
// ----------------------------------------------------------------------------
// sgd_ctrl: step sequencer
// Walks one sample through the multiply, compare, delta, saturation and
// division steps that it needs, then holds the result until it is taken.
// ----------------------------------------------------------------------------
module sgd_ctrl
  import sgd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     out_stall_i,
  input  sgd_sts_t sts_i,
  output sgd_ctl_t ctl_o
);

  sgd_step_e            state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    ctl_o.step       = state_q;
    ctl_o.accept     = 1'b0;
    ctl_o.in_stall   = 1'b1;
    ctl_o.out_valid  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        ctl_o.in_stall = 1'b0;
        ctl_o.accept   = in_valid_i;
        if (in_valid_i) begin
          // clear action and first sample need no arithmetic
          if (sts_i.action == ACT_CLEAR || !sts_i.have_prev) state_d = S_FIN;
          else state_d = S_MUL;
        end
      end
      S_MUL:  state_d = S_GROW;
      S_GROW: state_d = sts_i.grow ? S_DF : S_FIN;
      S_DF:   state_d = S_DG;
      S_DG:   state_d = S_DH;
      S_DH:   state_d = S_C1;
      S_C1:   state_d = S_C2;
      S_C2:   state_d = S_C3;
      S_C3:   state_d = S_SAT;
      S_SAT: begin
        cnt_d   = '0;
        state_d = sts_i.sat ? S_FIN : S_DIV;
      end
      S_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = S_FIN;
      end
      S_FIN:  state_d = S_OUT;
      S_OUT: begin
        ctl_o.out_valid = 1'b1;
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[design/sustained_growth_detector.sv]
// ----------------------------------------------------------------------------
// sustained_growth_detector: memory leak detector on periodic usage samples
// A growing sample runs multiply, 7 compare/delta steps, overflow check, 32
// divider steps and commit; a saturated ratio skips the divider; a sample
// with no growth commits after the compare; clear or first sample at once.
// Throughput: one beat at a time; the next beat is taken in the cycle after
// the result is accepted. The shared subtractor and its sequencer set this.
// Reset: asynchronous, active low; all detection state and counters clear.
// ----------------------------------------------------------------------------
module sustained_growth_detector
  import sgd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  // sample channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  action_i,
  input  logic [BYTE_WIDTH-1:0] used_bytes_i,
  input  logic [BYTE_WIDTH-1:0] frame_bytes_i,
  input  logic [BYTE_WIDTH-1:0] gpu_bytes_i,
  input  logic [BYTE_WIDTH-1:0] heap_bytes_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  leak_flag_o,
  output logic                  alert_pulse_o,
  output logic [RUN_OUT_W-1:0]  growth_run_o,
  output logic [RATIO_W-1:0]    ratio_q16_o,
  output logic [SUSP_W-1:0]     suspect_code_o,
  output logic [CNT32_W-1:0]    sample_total_o,
  output logic [CNT32_W-1:0]    alert_total_o
);

  sgd_ctl_t ctl;
  sgd_sts_t sts;

  // configuration registers
  logic [THR_W-1:0] thr_q;
  logic [SUS_W-1:0] sus_q;

  // captured beat (payload, no reset)
  logic                  action_q;
  logic [BYTE_WIDTH-1:0] tot_q, fr_q, gp_q, hp_q;

  // previous sample (cleared by reset as the detector starts from zero)
  logic [BYTE_WIDTH-1:0] prev_tot_q, prev_fr_q, prev_gp_q, prev_hp_q;
  logic                  have_prev_q;

  // detection state and counters
  logic [RUN_WIDTH-1:0] run_q;
  logic                 leak_q;
  logic                 pulse_q;
  logic [RATIO_W-1:0]   ratio_q;
  logic [SUSP_W-1:0]    susp_q;
  logic [CNT32_W-1:0]   samples_q;
  logic [CNT32_W-1:0]   alerts_q;

  // working registers of one item
  logic [PROD_W-1:0]     prod_a_q, prod_b_q;
  logic                  gt_q, grow_q, sat_q;
  logic [BYTE_WIDTH-1:0] df_q, dg_q, dh_q;
  logic                  fg_q, fh_q, gh_q;   // frame>gpu, frame>heap, gpu>heap
  logic [REM_W-1:0]      rem_q;
  logic [RATIO_W-1:0]    num_q;              // dividend bits out, quotient bits in

  // shared unit
  logic [ALU_W-1:0] alu_a, alu_b, alu_diff;
  logic             alu_ge;
  logic [REM_W-1:0] rem_shift;

  // update helpers
  logic [RUN_WIDTH-1:0] run_inc;
  logic [CNT32_W-1:0]   run_ext;
  logic [SUSP_W-1:0]    susp_new;

  sgd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  sgd_alu u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .diff_o (alu_diff),
    .ge_o   (alu_ge)
  );

  assign in_stall_o  = ctl.in_stall;
  assign out_valid_o = ctl.out_valid;

  // Feed the sequencer: branch on the live compare during the grow and
  // saturation steps.
  always_comb begin
    sts.action    = action_i;
    sts.have_prev = have_prev_q;
    sts.grow      = gt_q & alu_ge;
    sts.sat       = alu_ge;
  end

  // Shift the next dividend bit into the partial remainder. The remainder
  // stays below the previous total, so its top bit drops out safely.
  assign rem_shift = {rem_q[REM_W-2:0], num_q[RATIO_W-1]};

  // Operand steering for the shared subtractor.
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (ctl.step)
      S_MUL: begin                      // previous >= total means no growth
        alu_a = ALU_W'(prev_tot_q);
        alu_b = ALU_W'(tot_q);
      end
      S_GROW: begin                     // total*1000 >= previous*threshold
        alu_a = ALU_W'(prod_a_q);
        alu_b = ALU_W'(prod_b_q);
      end
      S_DF: begin
        alu_a = ALU_W'(fr_q);
        alu_b = ALU_W'(prev_fr_q);
      end
      S_DG: begin
        alu_a = ALU_W'(gp_q);
        alu_b = ALU_W'(prev_gp_q);
      end
      S_DH: begin
        alu_a = ALU_W'(hp_q);
        alu_b = ALU_W'(prev_hp_q);
      end
      S_C1: begin                       // gpu >= frame
        alu_a = ALU_W'(dg_q);
        alu_b = ALU_W'(df_q);
      end
      S_C2: begin                       // heap >= frame
        alu_a = ALU_W'(dh_q);
        alu_b = ALU_W'(df_q);
      end
      S_C3: begin                       // heap >= gpu
        alu_a = ALU_W'(dh_q);
        alu_b = ALU_W'(dg_q);
      end
      S_SAT: begin                      // quotient overflows 32 bits
        alu_a = ALU_W'(tot_q >> FRAC_W);
        alu_b = ALU_W'(prev_tot_q);
      end
      S_DIV: begin
        alu_a = ALU_W'(rem_shift);
        alu_b = ALU_W'(prev_tot_q);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      sus_q <= SUS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESHOLD: thr_q <= cfg_wdata_i[THR_W-1:0];
        CFG_SUSTAIN:   sus_q <= cfg_wdata_i[SUS_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the beat and run the working registers.
  always_ff @(posedge clk_i) begin
    if (ctl.accept) begin
      action_q <= action_i;
      tot_q    <= used_bytes_i;
      fr_q     <= frame_bytes_i;
      gp_q     <= gpu_bytes_i;
      hp_q     <= heap_bytes_i;
    end
    unique case (ctl.step)
      S_MUL: begin
        gt_q     <= ~alu_ge;
        prod_a_q <= PROD_W'(tot_q) * PROD_W'(GROWTH_SCALE);
        prod_b_q <= PROD_W'(prev_tot_q) * PROD_W'(thr_q);
      end
      S_GROW: grow_q <= gt_q & alu_ge;
      S_DF:   df_q   <= alu_diff[BYTE_WIDTH-1:0];
      S_DG:   dg_q   <= alu_diff[BYTE_WIDTH-1:0];
      S_DH:   dh_q   <= alu_diff[BYTE_WIDTH-1:0];
      S_C1:   fg_q   <= ~alu_ge;
      S_C2:   fh_q   <= ~alu_ge;
      S_C3:   gh_q   <= ~alu_ge;
      S_SAT: begin
        // the bits above the fraction are the first partial remainder
        sat_q <= alu_ge;
        rem_q <= REM_W'(tot_q >> FRAC_W);
        num_q <= RATIO_W'({tot_q[FRAC_W-1:0], {FRAC_W{1'b0}}});
      end
      S_DIV: begin
        rem_q <= alu_ge ? alu_diff[REM_W-1:0] : rem_shift;
        num_q <= {num_q[RATIO_W-2:0], alu_ge};
      end
      default: ;
    endcase
  end

  assign run_inc = (run_q == RUN_MAX) ? run_q : run_q + 1'b1;
  assign run_ext = CNT32_W'(run_q);

  always_comb begin
    if (fg_q && fh_q) susp_new = SUSP_FRAME;
    else if (gh_q)    susp_new = SUSP_GPU;
    else              susp_new = SUSP_HEAP;
  end

  // Commit the step to the detection state at the end of the item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_tot_q  <= '0;
      prev_fr_q   <= '0;
      prev_gp_q   <= '0;
      prev_hp_q   <= '0;
      have_prev_q <= 1'b0;
      run_q       <= '0;
      leak_q      <= 1'b0;
      pulse_q     <= 1'b0;
      ratio_q     <= '0;
      susp_q      <= SUSP_NONE;
      samples_q   <= '0;
      alerts_q    <= '0;
    end else if (ctl.step == S_FIN) begin
      pulse_q <= 1'b0;
      if (action_q == ACT_CLEAR) begin
        // forget the previous sample, keep the counters
        have_prev_q <= 1'b0;
        run_q       <= '0;
        leak_q      <= 1'b0;
        ratio_q     <= '0;
        susp_q      <= SUSP_NONE;
      end else begin
        samples_q <= samples_q + 1'b1;
        if (have_prev_q) begin
          if (grow_q) begin
            run_q   <= run_inc;
            ratio_q <= sat_q ? {RATIO_W{1'b1}} : num_q;
            susp_q  <= susp_new;
            if ((CNT32_W'(run_inc) >= CNT32_W'(sus_q)) && !leak_q) begin
              leak_q   <= 1'b1;
              alerts_q <= alerts_q + 1'b1;
              pulse_q  <= 1'b1;
            end
          end else begin
            run_q  <= '0;
            leak_q <= 1'b0;
          end
        end
        prev_tot_q  <= tot_q;
        prev_fr_q   <= fr_q;
        prev_gp_q   <= gp_q;
        prev_hp_q   <= hp_q;
        have_prev_q <= 1'b1;
      end
    end
  end

  // Result fields hold steady from the commit until the beat is taken.
  assign leak_flag_o    = leak_q;
  assign alert_pulse_o  = pulse_q;
  assign growth_run_o   = run_ext[RUN_OUT_W-1:0];
  assign ratio_q16_o    = ratio_q;
  assign suspect_code_o = susp_q;
  assign sample_total_o = samples_q;
  assign alert_total_o  = alerts_q;

endmodule

[tb/sv/sgd_result_checker.sv]
// ----------------------------------------------------------------------------
// sgd_result_checker: result prediction and compare for the growth detector
// Mirrors register writes, predicts one report per accepted sample beat from
// its own image of the detector, and compares every accepted result beat
// field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module sgd_result_checker
  import sgd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  action_i,
  input  logic [BYTE_WIDTH-1:0] used_bytes_i,
  input  logic [BYTE_WIDTH-1:0] frame_bytes_i,
  input  logic [BYTE_WIDTH-1:0] gpu_bytes_i,
  input  logic [BYTE_WIDTH-1:0] heap_bytes_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  leak_flag_i,
  input  logic                  alert_pulse_i,
  input  logic [RUN_OUT_W-1:0]  growth_run_i,
  input  logic [RATIO_W-1:0]    ratio_q16_i,
  input  logic [SUSP_W-1:0]     suspect_code_i,
  input  logic [CNT32_W-1:0]    sample_total_i,
  input  logic [CNT32_W-1:0]    alert_total_i,
  output int                    pending_o,
  output int                    fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic                 leak;
    logic                 pulse;
    logic [RUN_OUT_W-1:0] run;
    logic [RATIO_W-1:0]   ratio;
    logic [SUSP_W-1:0]    suspect;
    logic [CNT32_W-1:0]   samples;
    logic [CNT32_W-1:0]   alerts;
  } growth_report_t;

  // image of the detector
  logic [THR_W-1:0]      thr_permille;
  logic [SUS_W-1:0]      sustain_need;
  logic [BYTE_WIDTH-1:0] last_total, last_frame, last_gpu, last_heap;
  logic                  have_last;
  logic [RUN_WIDTH-1:0]  run_len;
  logic                  leak_on;
  logic [RATIO_W-1:0]    held_ratio;
  logic [SUSP_W-1:0]     held_suspect;
  logic [CNT32_W-1:0]    sample_cnt, alert_cnt;

  growth_report_t reports_due[$];
  growth_report_t want;
  int             faults = 0;
  int             result_no = 0;

  // floor(num * 2^16 / den), saturated; zero divisor saturates
  function automatic logic [RATIO_W-1:0] q16_quotient(input logic [BYTE_WIDTH-1:0] num,
                                                      input logic [BYTE_WIDTH-1:0] den);
    logic [63:0] whole;
    if (den == '0) return '1;
    whole = 64'(num) / 64'(den);
    if (whole >= (64'd1 << FRAC_W)) return '1;
    return RATIO_W'({num, {FRAC_W{1'b0}}} / 64'(den));
  endfunction

  function automatic growth_report_t advance_detector(input logic act,
                                                      input logic [BYTE_WIDTH-1:0] tot,
                                                      input logic [BYTE_WIDTH-1:0] fr,
                                                      input logic [BYTE_WIDTH-1:0] gp,
                                                      input logic [BYTE_WIDTH-1:0] hp);
    growth_report_t        rep;
    logic                  grow;
    logic                  pulse;
    logic [BYTE_WIDTH-1:0] df, dg, dh;
    grow  = 1'b0;
    pulse = 1'b0;
    if (act == ACT_CLEAR) begin
      // forget the previous sample, keep the lifetime counters
      have_last    = 1'b0;
      run_len      = '0;
      leak_on      = 1'b0;
      held_ratio   = '0;
      held_suspect = SUSP_NONE;
    end else begin
      sample_cnt = sample_cnt + 1'b1;
      if (have_last) begin
        if (tot > last_total)
          grow = 64'(tot) * 64'(GROWTH_SCALE) >= 64'(last_total) * 64'(thr_permille);
        if (grow) begin
          df = fr - last_frame;
          dg = gp - last_gpu;
          dh = hp - last_heap;
          if (run_len != RUN_MAX) run_len = run_len + 1'b1;
          held_ratio = q16_quotient(tot, last_total);
          if (df > dg && df > dh) held_suspect = SUSP_FRAME;
          else if (dg > dh) held_suspect = SUSP_GPU;
          else held_suspect = SUSP_HEAP;
          if (run_len >= sustain_need && !leak_on) begin
            leak_on   = 1'b1;
            alert_cnt = alert_cnt + 1'b1;
            pulse     = 1'b1;
          end
        end else begin
          run_len = '0;
          leak_on = 1'b0;
        end
      end
      last_total = tot;
      last_frame = fr;
      last_gpu   = gp;
      last_heap  = hp;
      have_last  = 1'b1;
    end
    rep.leak    = leak_on;
    rep.pulse   = pulse;
    rep.run     = RUN_OUT_W'(run_len);
    rep.ratio   = held_ratio;
    rep.suspect = held_suspect;
    rep.samples = sample_cnt;
    rep.alerts  = alert_cnt;
    return rep;
  endfunction

  task automatic check_field(input string field, input logic [63:0] exp_val,
                             input logic [63:0] got_val);
    if (exp_val !== got_val) begin
      faults++;
      if (faults <= REPORT_LIMIT)
        $display("result beat %0d: %s expected 0x%0h, got 0x%0h",
                 result_no, field, exp_val, got_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_permille = THR_RESET;
      sustain_need = SUS_RESET;
      last_total   = '0;
      last_frame   = '0;
      last_gpu     = '0;
      last_heap    = '0;
      have_last    = 1'b0;
      run_len      = '0;
      leak_on      = 1'b0;
      held_ratio   = '0;
      held_suspect = SUSP_NONE;
      sample_cnt   = '0;
      alert_cnt    = '0;
      reports_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_THRESHOLD: thr_permille = cfg_wdata_i[THR_W-1:0];
          CFG_SUSTAIN:   sustain_need = cfg_wdata_i[SUS_W-1:0];
          default: ;
        endcase
      end
      // retire the result beat before queuing a new prediction
      if (out_valid_i && !out_stall_i) begin
        result_no++;
        if (reports_due.size() == 0) begin
          faults++;
          if (faults <= REPORT_LIMIT)
            $display("result beat %0d arrived with no prediction waiting", result_no);
        end else begin
          want = reports_due.pop_front();
          check_field("leak_flag",    want.leak,    leak_flag_i);
          check_field("alert_pulse",  want.pulse,   alert_pulse_i);
          check_field("growth_run",   want.run,     growth_run_i);
          check_field("ratio_q16",    want.ratio,   ratio_q16_i);
          check_field("suspect_code", want.suspect, suspect_code_i);
          check_field("sample_total", want.samples, sample_total_i);
          check_field("alert_total",  want.alerts,  alert_total_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        reports_due.push_back(advance_detector(action_i, used_bytes_i, frame_bytes_i,
                                               gpu_bytes_i, heap_bytes_i));
    end
    pending_o    <= reports_due.size();
    fail_count_o <= faults + reports_due.size();
  end

endmodule

[tb/sv/sustained_growth_detector_test.sv]
// ----------------------------------------------------------------------------
// sustained_growth_detector_test: stimulus and verdict for the growth detector
// Drives a short directed set of samples (threshold edges, zero and full-scale
// totals, ratio saturation, suspect ties, leak rise and drop, clear actions),
// then phases of random growth runs under several register settings with
// random idling on both channels. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module sustained_growth_detector_test
  import sgd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 7;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES   = 600;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 8;     // idle time before a register write
  localparam int DRAIN_CYCLES  = 60;    // above the growing-sample latency
  localparam logic [BYTE_WIDTH-1:0] BYTES_MAX = '1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = CFG_THRESHOLD;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  action = ACT_SAMPLE;
  logic [BYTE_WIDTH-1:0] used_bytes = '0;
  logic [BYTE_WIDTH-1:0] frame_bytes = '0;
  logic [BYTE_WIDTH-1:0] gpu_bytes = '0;
  logic [BYTE_WIDTH-1:0] heap_bytes = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  leak_flag;
  logic                  alert_pulse;
  logic [RUN_OUT_W-1:0]  growth_run;
  logic [RATIO_W-1:0]    ratio_q16;
  logic [SUSP_W-1:0]     suspect_code;
  logic [CNT32_W-1:0]    sample_total;
  logic [CNT32_W-1:0]    alert_total;

  int pending;
  int fail_count;
  int cycles = 0;
  int sent = 0;

  // idling controls, flipped per phase
  bit src_gaps = 1'b0;
  bit sink_stalls = 1'b0;
  bit hold_req = 1'b0;

  // last sample sent, used only to shape the next one
  logic [BYTE_WIDTH-1:0] last_total = '0;
  logic [BYTE_WIDTH-1:0] last_frame = '0;
  logic [BYTE_WIDTH-1:0] last_gpu = '0;
  logic [BYTE_WIDTH-1:0] last_heap = '0;
  bit                    last_known = 1'b0;

  sustained_growth_detector uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (action),
    .used_bytes_i   (used_bytes),
    .frame_bytes_i  (frame_bytes),
    .gpu_bytes_i    (gpu_bytes),
    .heap_bytes_i   (heap_bytes),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .leak_flag_o    (leak_flag),
    .alert_pulse_o  (alert_pulse),
    .growth_run_o   (growth_run),
    .ratio_q16_o    (ratio_q16),
    .suspect_code_o (suspect_code),
    .sample_total_o (sample_total),
    .alert_total_o  (alert_total)
  );

  sgd_result_checker result_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .action_i       (action),
    .used_bytes_i   (used_bytes),
    .frame_bytes_i  (frame_bytes),
    .gpu_bytes_i    (gpu_bytes),
    .heap_bytes_i   (heap_bytes),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .leak_flag_i    (leak_flag),
    .alert_pulse_i  (alert_pulse),
    .growth_run_i   (growth_run),
    .ratio_q16_i    (ratio_q16),
    .suspect_code_i (suspect_code),
    .sample_total_i (sample_total),
    .alert_total_i  (alert_total),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [BYTE_WIDTH-1:0] random_bytes();
    return BYTE_WIDTH'({$urandom, $urandom});
  endfunction

  // Move one pool: small growth, a wild jump (may wrap), no change, or a big step.
  function automatic logic [BYTE_WIDTH-1:0] grown_pool(input logic [BYTE_WIDTH-1:0] prev);
    case ($urandom_range(0, 3))
      0:       return prev + BYTE_WIDTH'($urandom_range(0, 4096));
      1:       return random_bytes();
      2:       return prev;
      default: return prev + BYTE_WIDTH'($urandom);
    endcase
  endfunction

  // Smallest total that still counts as a growth step over prev.
  function automatic logic [63:0] growth_floor(input logic [BYTE_WIDTH-1:0] prev,
                                               input logic [THR_W-1:0] thr);
    logic [63:0] need;
    need = (64'(prev) * 64'(thr) + 64'(GROWTH_SCALE) - 64'd1) / 64'(GROWTH_SCALE);
    if (need <= 64'(prev)) need = 64'(prev) + 64'd1;
    return need;
  endfunction

  // Offer one sample beat and hold it until accepted. Optionally idle first.
  task automatic send_beat(input logic act, input logic [BYTE_WIDTH-1:0] tot,
                           input logic [BYTE_WIDTH-1:0] fr, input logic [BYTE_WIDTH-1:0] gp,
                           input logic [BYTE_WIDTH-1:0] hp);
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    used_bytes  <= tot;
    frame_bytes <= fr;
    gpu_bytes   <= gp;
    heap_bytes  <= hp;
    do @(posedge clk); while (in_stall);
    sent++;
    if (act == ACT_CLEAR) begin
      last_known = 1'b0;
    end else begin
      last_total = tot;
      last_frame = fr;
      last_gpu   = gp;
      last_heap  = hp;
      last_known = 1'b1;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait for every predicted result, then let the block go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [CFG_W-1:0] thr_word, input logic [SUS_W-1:0] sus);
    settle();
    write_reg(CFG_THRESHOLD, thr_word);
    write_reg(CFG_SUSTAIN, CFG_W'(sus));
  endtask

  // One well-formed growth run: optional clear and seed samples, a chain of
  // growth steps (some exactly on the threshold), then usually a breaker.
  task automatic run_episode(input logic [THR_W-1:0] thr, input int steps);
    logic [63:0]           need;
    logic [63:0]           nxt;
    logic [BYTE_WIDTH-1:0] d;
    logic [BYTE_WIDTH-1:0] seed_total;
    int                    k;
    if ($urandom_range(0, 3) == 0)
      send_beat(ACT_CLEAR, random_bytes(), random_bytes(), random_bytes(), random_bytes());
    if (!last_known || $urandom_range(0, 2) == 0) begin
      // a zero seed makes the next growth ratio saturate
      seed_total = ($urandom_range(0, 7) == 0) ? BYTE_WIDTH'(0)
                                               : BYTE_WIDTH'($urandom_range(1, 1 << 20));
      send_beat(ACT_SAMPLE, seed_total, random_bytes(), random_bytes(), random_bytes());
    end
    for (k = 0; k < steps; k++) begin
      need = growth_floor(last_total, thr);
      case ($urandom_range(0, 3))
        0:       nxt = need;
        1:       nxt = need + 64'($urandom_range(1, 7));
        default: nxt = need + (need >> $urandom_range(1, 12));
      endcase
      if (nxt > 64'(BYTES_MAX)) break;
      if ($urandom_range(0, 4) == 0) begin
        // equal deltas on all pools: heap wins the tie
        d = BYTE_WIDTH'($urandom_range(0, 4096));
        send_beat(ACT_SAMPLE, BYTE_WIDTH'(nxt), last_frame + d, last_gpu + d, last_heap + d);
      end else begin
        send_beat(ACT_SAMPLE, BYTE_WIDTH'(nxt), grown_pool(last_frame),
                  grown_pool(last_gpu), grown_pool(last_heap));
      end
    end
    case ($urandom_range(0, 3))
      0: send_beat(ACT_SAMPLE, last_total, grown_pool(last_frame), grown_pool(last_gpu),
                   grown_pool(last_heap));
      1: send_beat(ACT_SAMPLE, BYTE_WIDTH'(64'(last_total) >> $urandom_range(1, 8)),
                   grown_pool(last_frame), grown_pool(last_gpu), grown_pool(last_heap));
      2: begin
        // one below the growth floor
        need = growth_floor(last_total, thr) - 64'd1;
        if (need > 64'(BYTES_MAX)) need = 64'(last_total);
        send_beat(ACT_SAMPLE, BYTE_WIDTH'(need), grown_pool(last_frame),
                  grown_pool(last_gpu), grown_pool(last_heap));
      end
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] thr_word, input logic [SUS_W-1:0] sus,
                           input int quota);
    int first;
    int cap;
    reconfigure(thr_word, sus);
    first = sent;
    // runs reach a little past a sustain count under 16 so leaks rise and hold
    cap = (sus < 16) ? int'(sus) + 4 : 20;
    while (sent - first < quota) begin
      if ($urandom_range(0, 7) == 0)
        send_beat(1'($urandom_range(0, 1)), random_bytes(), random_bytes(),
                  random_bytes(), random_bytes());
      else
        run_episode(thr_word[THR_W-1:0], $urandom_range(1, cap));
    end
  endtask

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin : result_sink
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (sink_stalls && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : sample_source
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset register values first.
    sink_stalls = 1'b1;
    send_beat(ACT_SAMPLE, '0, '0, '0, '0);              // first sample: store only
    send_beat(ACT_SAMPLE, '0, '0, '0, '0);              // flat: no growth
    send_beat(ACT_SAMPLE, 48'd7, 48'd1, 48'd2, 48'd3);  // previous zero: ratio saturates
    // quotient overflow; frame ties gpu after wrap, gpu beats heap
    send_beat(ACT_SAMPLE, BYTES_MAX, BYTES_MAX, '0, '0);
    send_beat(ACT_SAMPLE, BYTES_MAX, '0, BYTES_MAX, '0); // flat at full scale
    send_beat(ACT_CLEAR, BYTES_MAX, BYTES_MAX, BYTES_MAX, BYTES_MAX);
    send_beat(ACT_SAMPLE, 48'd1000, 48'd10, 48'd10, 48'd10);
    send_beat(ACT_SAMPLE, 48'd1050, 48'd20, 48'd20, 48'd20);  // exactly on threshold
    send_beat(ACT_SAMPLE, 48'd1102, 48'd25, 48'd25, 48'd25);  // just under threshold
    send_beat(ACT_SAMPLE, 48'd2000, 48'd100, 48'd30, 48'd30); // frame largest
    send_beat(ACT_SAMPLE, 48'd3000, 48'd100, 48'd900, 48'd30); // gpu largest
    send_beat(ACT_CLEAR, '0, '0, '0, '0);

    // Lowest threshold, upper data bits set to show they are dropped.
    reconfigure(16'hF3E9, 16'd2);
    send_beat(ACT_SAMPLE, 48'd1000, '0, '0, '0);
    send_beat(ACT_SAMPLE, 48'd1001, 48'd50, 48'd10, 48'd50);  // frame ties heap
    send_beat(ACT_SAMPLE, 48'd1002, 48'd50, 48'd10, 48'd50);
    send_beat(ACT_SAMPLE, 48'd100000, 48'd51, 48'd11, 48'd51);
    send_beat(ACT_SAMPLE, 48'd100100, 48'd52, 48'd12, 48'd52); // leak rises
    send_beat(ACT_SAMPLE, 48'd200200, 48'd53, 48'd13, 48'd53); // no second alert
    send_beat(ACT_SAMPLE, 48'd200200, 48'd54, 48'd14, 48'd54); // leak drops

    // Highest threshold, sustain zero: the first growth step flags.
    reconfigure(16'd4000, 16'd0);
    send_beat(ACT_SAMPLE, 48'd10, '0, '0, '0);
    send_beat(ACT_SAMPLE, 48'd40, 48'd1, 48'd1, 48'd1);
    send_beat(ACT_SAMPLE, 48'd159, 48'd2, 48'd2, 48'd2);
    send_beat(ACT_CLEAR, random_bytes(), random_bytes(), random_bytes(), random_bytes());
    send_beat(ACT_SAMPLE, 48'd1, '0, '0, '0);
    send_beat(ACT_SAMPLE, 48'd4, '0, '0, '0);

    // Random phases. Hold the result side for a long stretch in the first one.
    src_gaps = 1'b1;
    hold_req = 1'b1;
    run_phase(16'd1050, 16'd10, 250);
    sink_stalls = 1'b0;
    run_phase(16'hF3E9, 16'd1, 250);
    src_gaps = 1'b0;
    sink_stalls = 1'b1;
    run_phase(16'd4000, 16'd3, 250);
    src_gaps = 1'b1;
    run_phase(16'd0, 16'd0, 200);       // threshold below range: any rise grows
    run_phase(16'd4095, 16'd2, 200);
    run_phase({4'($urandom), 12'($urandom_range(1001, 4000))}, 16'hFFFF, 200);
    run_phase(16'($urandom_range(1001, 4000)), 16'($urandom_range(1, 12)), 300);

    // Last stretch runs at full rate on both sides.
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    run_phase(16'($urandom_range(1001, 4000)), 16'($urandom_range(1, 12)), 300);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
